// ===== design/bpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpmd_pkg
// Shared widths, register map, reset values and stage structs for the
// balance PID motor drive.
// ----------------------------------------------------------------------------
package bpmd_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 20;
  localparam int LIMIT_W = 18;
  localparam int DUTY_W  = 15;
  localparam int BAND_W  = 16;
  localparam int ANGLE_W = 17;
  localparam int DIFF_W  = 18;
  localparam int SUM_W   = 19;
  localparam int SUMX_W  = 20;
  localparam int DIR_W   = 2;
  localparam int PP_W    = 38;
  localparam int PI_W    = 40;
  localparam int PD_W    = 39;
  localparam int CORR_W  = 41;
  localparam int MAG_W   = 42;

  localparam logic [DUTY_W-1:0] CORR_MAX = 15'd23040;

  localparam logic [GAIN_W-1:0]  RST_GAIN_PROP    = 20'd61440;
  localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG   = 20'd307;
  localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV   = 20'd36864;
  localparam logic [LIMIT_W-1:0] RST_SUM_LIMIT    = 18'd217600;
  localparam logic [DUTY_W-1:0]  RST_DUTY_FLOOR   = 15'd15360;
  localparam logic [DUTY_W-1:0]  RST_DUTY_CEILING = 15'd23040;
  localparam logic [BAND_W-1:0]  RST_DEAD_BAND    = 16'd256;

  typedef enum logic [2:0] {
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV,
    REG_SUM_LIMIT,
    REG_DUTY_FLOOR,
    REG_DUTY_CEILING,
    REG_DEAD_BAND
  } reg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP,
    DIR_FORWARD,
    DIR_BACKWARD
  } dir_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
    logic [LIMIT_W-1:0] sum_limit;
    logic [DUTY_W-1:0]  duty_floor;
    logic [DUTY_W-1:0]  duty_ceiling;
    logic [BAND_W-1:0]  dead_band;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W-1:0]   sum;
    dir_t                      dir;
  } integ_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] corr;
    logic signed [SUM_W-1:0]  sum;
    dir_t                     dir;
  } corr_t;

endpackage

// ===== design/balance_pid_motor_drive.sv =====
// ----------------------------------------------------------------------------
// balance_pid_motor_drive
// PID balance controller: pitch angle in, motor duty and direction out.
// ----------------------------------------------------------------------------
// Each angle transaction is taken as the error and yields exactly one result
// transaction, in order. The block is a five-stage pipeline: input register,
// error history (clamped sum, difference, direction), gain multiplies,
// correction sum, and magnitude/duty shaping into the result register. It
// accepts one transaction per cycle while the result side does not stall. The
// per-cycle rate is set by the error-sum register, whose add-and-clamp feeds
// back into that register combinationally. A stalled result holds only the
// stages behind it; empty stages still fill, so angles keep flowing until
// every stage is occupied. Registers sit on an APB port at byte address
// 4*index; write them only while the pipeline is empty. Direction stop still
// carries the band-limited duty; if the floor is set above the ceiling, the
// floor wins for small corrections.
// ----------------------------------------------------------------------------
module balance_pid_motor_drive
  import bpmd_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 12
)(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      angle_valid,
  output logic                      angle_ready,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [DUTY_W-1:0]         duty,
  output logic [DIR_W-1:0]          direction,
  output logic [DUTY_W-1:0]         correction_mag,
  output logic signed [SUM_W-1:0]   error_sum
);

  cfg_t   cfg;
  integ_t integ_q;
  corr_t  corr_q;

  // Stage valids: 0 input register, 1 history, 2 products, 3 correction,
  // 4 result register.
  logic                      v0, v1, v2, v3, v4;
  logic                      en0, en1, en2, en3, en4;
  logic signed [ANGLE_W-1:0] angle_q;

  assign pready = 1'b1;

  // A stage advances when it is empty or its content moves on.
  assign en4 = !v4 || result_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;

  assign angle_ready  = en0;
  assign result_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en0) v0 <= angle_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Capture the angle of each accepted transaction.
  always_ff @(posedge clk) begin
    if (en0 && angle_valid) begin
      angle_q <= angle;
    end
  end

  bpmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Update the error history only when a real item moves on, so bubbles
  // leave the running sum untouched.
  bpmd_integ u_integ (
    .clk     (clk),
    .rst     (rst),
    .advance (v0 && en1),
    .err     (angle_q),
    .cfg     (cfg),
    .q       (integ_q)
  );

  bpmd_gain u_gain (
    .clk      (clk),
    .load_mul (v1 && en2),
    .load_sum (v2 && en3),
    .d        (integ_q),
    .cfg      (cfg),
    .q        (corr_q)
  );

  bpmd_shape #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_shape (
    .clk            (clk),
    .load           (v3 && en4),
    .d              (corr_q),
    .cfg            (cfg),
    .duty           (duty),
    .direction      (direction),
    .correction_mag (correction_mag),
    .error_sum      (error_sum)
  );

  // Sum held within the configured limit.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (SUMX_W'(error_sum) <= signed'({2'b00, cfg.sum_limit})) &&
                     (SUMX_W'(error_sum) >= -signed'({2'b00, cfg.sum_limit})))
    else $error("error_sum outside the sum limit");

  // Correction magnitude clamped to 90 units.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> correction_mag <= CORR_MAX)
    else $error("correction_mag above clamp");

  // With a sane band, the duty sits inside it.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && cfg.duty_floor <= cfg.duty_ceiling) |->
      (duty >= cfg.duty_floor) && (duty <= cfg.duty_ceiling))
    else $error("duty outside the configured band");

  // A stalled result stays put while the pipeline behind it fills.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid && $stable(duty) &&
                                        $stable(error_sum))
    else $error("result register changed under stall");

endmodule

// ===== design/bpmd_regs.sv =====
// ----------------------------------------------------------------------------
// bpmd_regs
// APB register file holding the gains, limits and dead band.
// ----------------------------------------------------------------------------
module bpmd_regs
  import bpmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[4:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop    <= RST_GAIN_PROP;
      cfg.gain_integ   <= RST_GAIN_INTEG;
      cfg.gain_deriv   <= RST_GAIN_DERIV;
      cfg.sum_limit    <= RST_SUM_LIMIT;
      cfg.duty_floor   <= RST_DUTY_FLOOR;
      cfg.duty_ceiling <= RST_DUTY_CEILING;
      cfg.dead_band    <= RST_DEAD_BAND;
    end else if (wr) begin
      case (idx)
        REG_GAIN_PROP:    cfg.gain_prop    <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG:   cfg.gain_integ   <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:   cfg.gain_deriv   <= pwdata[GAIN_W-1:0];
        REG_SUM_LIMIT:    cfg.sum_limit    <= pwdata[LIMIT_W-1:0];
        REG_DUTY_FLOOR:   cfg.duty_floor   <= pwdata[DUTY_W-1:0];
        REG_DUTY_CEILING: cfg.duty_ceiling <= pwdata[DUTY_W-1:0];
        REG_DEAD_BAND:    cfg.dead_band    <= pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_PROP:    prdata = DATA_W'(cfg.gain_prop);
      REG_GAIN_INTEG:   prdata = DATA_W'(cfg.gain_integ);
      REG_GAIN_DERIV:   prdata = DATA_W'(cfg.gain_deriv);
      REG_SUM_LIMIT:    prdata = DATA_W'(cfg.sum_limit);
      REG_DUTY_FLOOR:   prdata = DATA_W'(cfg.duty_floor);
      REG_DUTY_CEILING: prdata = DATA_W'(cfg.duty_ceiling);
      REG_DEAD_BAND:    prdata = DATA_W'(cfg.dead_band);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== design/bpmd_integ.sv =====
// ----------------------------------------------------------------------------
// bpmd_integ
// Error history: clamped running sum, error difference and direction.
// ----------------------------------------------------------------------------
module bpmd_integ
  import bpmd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic signed [ANGLE_W-1:0] err,
  input  cfg_t                      cfg,
  output integ_t                    q
);

  logic signed [ANGLE_W-1:0] last_error;
  logic signed [SUM_W-1:0]   accumulated_error;
  logic signed [SUMX_W-1:0]  sum_raw;
  logic signed [SUMX_W-1:0]  lim;
  logic signed [SUMX_W-1:0]  sum_c;
  logic signed [DIFF_W-1:0]  err_x;
  logic signed [DIFF_W-1:0]  db;
  integ_t                    q_next;

  assign sum_raw = SUMX_W'(accumulated_error) + SUMX_W'(err);
  assign lim     = signed'({2'b00, cfg.sum_limit});
  assign err_x   = DIFF_W'(err);
  assign db      = signed'({2'b00, cfg.dead_band});

  always_comb begin
    if (sum_raw > lim) begin
      sum_c = lim;
    end else if (sum_raw < -lim) begin
      sum_c = -lim;
    end else begin
      sum_c = sum_raw;
    end
    q_next.err  = err;
    q_next.diff = err_x - DIFF_W'(last_error);
    q_next.sum  = sum_c[SUM_W-1:0];
    if (err_x > db) begin
      q_next.dir = DIR_FORWARD;
    end else if (err_x < -db) begin
      q_next.dir = DIR_BACKWARD;
    end else begin
      q_next.dir = DIR_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error        <= '0;
      accumulated_error <= '0;
    end else if (advance) begin
      last_error        <= err;
      accumulated_error <= q_next.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q <= q_next;
    end
  end

endmodule

// ===== design/bpmd_gain.sv =====
// ----------------------------------------------------------------------------
// bpmd_gain
// Gain multiplies (one stage) and the three-way correction sum (one stage).
// ----------------------------------------------------------------------------
module bpmd_gain
  import bpmd_pkg::*;
(
  input  logic   clk,
  input  logic   load_mul,
  input  logic   load_sum,
  input  integ_t d,
  input  cfg_t   cfg,
  output corr_t  q
);

  logic signed [PP_W-1:0]  pp;
  logic signed [PI_W-1:0]  pi;
  logic signed [PD_W-1:0]  pd;
  logic signed [SUM_W-1:0] sum_m;
  dir_t                    dir_m;

  always_ff @(posedge clk) begin
    if (load_mul) begin
      pp    <= PP_W'(signed'({1'b0, cfg.gain_prop}))  * PP_W'(d.err);
      pi    <= PI_W'(signed'({1'b0, cfg.gain_integ})) * PI_W'(d.sum);
      pd    <= PD_W'(signed'({1'b0, cfg.gain_deriv})) * PD_W'(d.diff);
      sum_m <= d.sum;
      dir_m <= d.dir;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sum) begin
      q.corr <= CORR_W'(pp) + CORR_W'(pi) + CORR_W'(pd);
      q.sum  <= sum_m;
      q.dir  <= dir_m;
    end
  end

endmodule

// ===== design/bpmd_shape.sv =====
// ----------------------------------------------------------------------------
// bpmd_shape
// Magnitude, rounding, 90-unit clamp and duty band; holds the result register.
// ----------------------------------------------------------------------------
module bpmd_shape
  import bpmd_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 12
)(
  input  logic                    clk,
  input  logic                    load,
  input  corr_t                   d,
  input  cfg_t                    cfg,
  output logic [DUTY_W-1:0]       duty,
  output logic [DIR_W-1:0]        direction,
  output logic [DUTY_W-1:0]       correction_mag,
  output logic signed [SUM_W-1:0] error_sum
);

  localparam logic [MAG_W-1:0] RND = MAG_W'(1) << (GAIN_FRAC_BITS - 1);

  logic [CORR_W-1:0] mag;
  logic [MAG_W-1:0]  mag_rnd;
  logic [DUTY_W-1:0] mag_c;
  logic [DUTY_W-1:0] duty_next;

  always_comb begin
    mag     = d.corr[CORR_W-1] ? CORR_W'(-d.corr) : CORR_W'(d.corr);
    mag_rnd = (MAG_W'(mag) + RND) >> GAIN_FRAC_BITS;
    mag_c   = (mag_rnd > MAG_W'(CORR_MAX)) ? CORR_MAX : mag_rnd[DUTY_W-1:0];
    if (mag_c < cfg.duty_floor) begin
      duty_next = cfg.duty_floor;
    end else if (mag_c > cfg.duty_ceiling) begin
      duty_next = cfg.duty_ceiling;
    end else begin
      duty_next = mag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty           <= duty_next;
      direction      <= d.dir;
      correction_mag <= mag_c;
      error_sum      <= d.sum;
    end
  end

endmodule

// ===== dv/bpmd_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpmd_drive_checker
// Watches the register port and both transaction channels of the balance PID
// motor drive, predicts each drive result and compares it field by field.
// ----------------------------------------------------------------------------
module bpmd_drive_checker
  import bpmd_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 12
)(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  input  logic                      angle_valid,
  input  logic                      angle_ready,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic [DUTY_W-1:0]         duty,
  input  logic [DIR_W-1:0]          direction,
  input  logic [DUTY_W-1:0]         correction_mag,
  input  logic signed [SUM_W-1:0]   error_sum,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    dir_t                    dir;
    logic [DUTY_W-1:0]       mag;
    logic signed [SUM_W-1:0] sum;
  } drive_t;

  cfg_t                      cfg;
  logic signed [ANGLE_W-1:0] prev_err;
  logic signed [SUM_W-1:0]   err_sum_q;
  drive_t                    drive_q[$];
  int                        reported;

  // Work out the drive for one angle and advance the error history.
  function automatic drive_t advance_drive(input logic signed [ANGLE_W-1:0] err);
    longint e;
    longint s;
    longint lim;
    longint db;
    longint corr;
    longint m;
    longint d;
    drive_t r;
    e   = err;
    lim = longint'(cfg.sum_limit);
    db  = longint'(cfg.dead_band);
    s   = longint'(err_sum_q) + e;
    if (s > lim) begin
      s = lim;
    end else if (s < -lim) begin
      s = -lim;
    end
    corr = longint'(cfg.gain_prop) * e + longint'(cfg.gain_integ) * s
         + longint'(cfg.gain_deriv) * (e - longint'(prev_err));
    m = (corr < 0) ? -corr : corr;
    // round halves away from zero on the magnitude
    m = (m + (longint'(1) << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
    if (m > longint'(CORR_MAX)) begin
      m = longint'(CORR_MAX);
    end
    // floor test first, so a floor above the ceiling wins for small values
    if (m < longint'(cfg.duty_floor)) begin
      d = longint'(cfg.duty_floor);
    end else if (m > longint'(cfg.duty_ceiling)) begin
      d = longint'(cfg.duty_ceiling);
    end else begin
      d = m;
    end
    if (e > db) begin
      r.dir = DIR_FORWARD;
    end else if (e < -db) begin
      r.dir = DIR_BACKWARD;
    end else begin
      r.dir = DIR_STOP;
    end
    r.duty    = d[DUTY_W-1:0];
    r.mag     = m[DUTY_W-1:0];
    r.sum     = s[SUM_W-1:0];
    err_sum_q = s[SUM_W-1:0];
    prev_err  = err;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    reported   = 0;
  end

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      cfg       = '{RST_GAIN_PROP, RST_GAIN_INTEG, RST_GAIN_DERIV, RST_SUM_LIMIT,
                    RST_DUTY_FLOOR, RST_DUTY_CEILING, RST_DEAD_BAND};
      prev_err  = '0;
      err_sum_q = '0;
      drive_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_GAIN_PROP:    cfg.gain_prop    = pwdata[GAIN_W-1:0];
          REG_GAIN_INTEG:   cfg.gain_integ   = pwdata[GAIN_W-1:0];
          REG_GAIN_DERIV:   cfg.gain_deriv   = pwdata[GAIN_W-1:0];
          REG_SUM_LIMIT:    cfg.sum_limit    = pwdata[LIMIT_W-1:0];
          REG_DUTY_FLOOR:   cfg.duty_floor   = pwdata[DUTY_W-1:0];
          REG_DUTY_CEILING: cfg.duty_ceiling = pwdata[DUTY_W-1:0];
          REG_DEAD_BAND:    cfg.dead_band    = pwdata[BAND_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (drive_q.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: drive result with nothing expected: duty=%0d dir=%0d mag=%0d sum=%0d",
                     $time, duty, direction, correction_mag, error_sum);
          end
        end else begin
          want = drive_q.pop_front();
          if (duty !== want.duty || direction !== want.dir ||
              correction_mag !== want.mag || error_sum !== want.sum) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: drive mismatch: expected duty=%0d dir=%0d mag=%0d sum=%0d",
                       $time, want.duty, want.dir, want.mag, want.sum);
              $display("%0t:                 actual   duty=%0d dir=%0d mag=%0d sum=%0d",
                       $time, duty, direction, correction_mag, error_sum);
            end
          end
        end
      end
      if (angle_valid && angle_ready) begin
        drive_q.push_back(advance_drive(angle));
      end
    end
    pending = drive_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the balance PID motor drive.
// ----------------------------------------------------------------------------
// Drives pitch angles through the valid/ready input, soaks up drive results
// with random back-pressure, and reprograms the seven registers between
// phases. A directed opening covers the field extremes, the dead-band edges,
// sum saturation, a floor set above the ceiling and a write to an unused
// register slot; random phases follow with a mix of smooth angle walks and
// noise. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import bpmd_pkg::*;

  localparam int GAIN_FRAC_BITS = 12;
  localparam int PHASE_ITEMS    = 250;
  localparam int PHASE_COUNT    = 8;
  localparam int DRAIN_CYCLES   = 10;   // pipeline is five deep, allow some slack
  localparam int STALL_LIMIT    = 2000; // cycles without any transaction

  // spare address slot past the last register; writes there must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      angle_valid;
  logic                      angle_ready;
  logic signed [ANGLE_W-1:0] angle;
  logic                      result_valid;
  logic                      result_ready;
  logic [DUTY_W-1:0]         duty;
  logic [DIR_W-1:0]          direction;
  logic [DUTY_W-1:0]         correction_mag;
  logic signed [SUM_W-1:0]   error_sum;

  int   fail_count;
  int   pending;
  bit   idling;
  int   walk_angle;
  int   band_now;
  int   stall_cycles;

  balance_pid_motor_drive #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .angle_valid    (angle_valid),
    .angle_ready    (angle_ready),
    .angle          (angle),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .duty           (duty),
    .direction      (direction),
    .correction_mag (correction_mag),
    .error_sum      (error_sum)
  );

  bpmd_drive_checker #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) drive_check (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .angle_valid    (angle_valid),
    .angle_ready    (angle_ready),
    .angle          (angle),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .duty           (duty),
    .direction      (direction),
    .correction_mag (correction_mag),
    .error_sum      (error_sum),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Result side: drop ready for short random bursts while idling is on,
  // otherwise hold it high. One update per falling edge at most.
  initial begin
    result_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  // Watchdog: abort once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (angle_valid && angle_ready) || (result_valid && result_ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Register write: setup phase, access phase, then a quiet spell with psel low so the
  // next write never lowers and raises psel in the same step.
  task automatic write_reg(input logic [2:0] index, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Sometimes set bits above the register width; the block must mask them.
  function automatic logic [DATA_W-1:0] with_stray_bits(input logic [DATA_W-1:0] v,
                                                        input int w);
    if ($urandom_range(0, 1) == 1) begin
      return v | ($urandom() << w);
    end
    return v;
  endfunction

  task automatic load_drive_config(input int gp, input int gi, input int gd, input int lim,
                                   input int floor_v, input int ceil_v, input int band);
    write_reg(REG_GAIN_PROP,    with_stray_bits(gp, GAIN_W));
    write_reg(REG_GAIN_INTEG,   with_stray_bits(gi, GAIN_W));
    write_reg(REG_GAIN_DERIV,   with_stray_bits(gd, GAIN_W));
    write_reg(REG_SUM_LIMIT,    with_stray_bits(lim, LIMIT_W));
    write_reg(REG_DUTY_FLOOR,   with_stray_bits(floor_v, DUTY_W));
    write_reg(REG_DUTY_CEILING, with_stray_bits(ceil_v, DUTY_W));
    write_reg(REG_DEAD_BAND,    with_stray_bits(band, BAND_W));
    band_now = band;
  endtask

  // Send one angle transaction. Valid stays high on return; the next call
  // either holds it with a new payload or drops it for an idle burst.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] value);
    if (idling && $urandom_range(0, 4) == 0) begin
      angle_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    angle_valid <= 1'b1;
    angle       <= value;
    do @(posedge clk); while (!angle_ready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every result to land, then let the pipe go quiet.
  task automatic drain_pipeline();
    angle_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic int rand_gain();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 8192);
      1:       return $urandom_range(32768, 65536);
      2:       return $urandom_range(0, 1048575);
      default: return 1048575;
    endcase
  endfunction

  function automatic int rand_limit();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1024);
      1:       return $urandom_range(0, 40000);
      2:       return $urandom_range(0, 262143);
      default: return 262143;
    endcase
  endfunction

  function automatic int rand_duty();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 25600;
      2:       return $urandom_range(25601, 32767);
      default: return $urandom_range(0, 25600);
    endcase
  endfunction

  // Mostly a smooth pitch walk so the error sum builds up and saturates;
  // the rest is uniform angles, raw 17-bit noise and dead-band edges.
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int mode;
    int edge_v;
    mode = $urandom_range(0, 99);
    if (mode < 55) begin
      walk_angle += int'($urandom_range(0, 1024)) - 512;
      if (walk_angle > 46080) begin
        walk_angle = 46080;
      end else if (walk_angle < -46080) begin
        walk_angle = -46080;
      end
      return ANGLE_W'(walk_angle);
    end else if (mode < 75) begin
      return ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
    end else if (mode < 85) begin
      return ANGLE_W'($urandom());
    end
    edge_v = band_now + int'($urandom_range(0, 4)) - 2;
    return ANGLE_W'(($urandom_range(0, 1) == 1) ? edge_v : -edge_v);
  endfunction

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    angle_valid  = 1'b0;
    angle        = '0;
    idling       = 1'b0;
    walk_angle   = 0;
    band_now     = 256;
    stall_cycles = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at reset settings: dead-band edges, full-scale angles,
    // raw extremes of the 17-bit field and a climb into the sum clamp.
    send_angle(0);
    send_angle(256);
    send_angle(257);
    send_angle(-256);
    send_angle(-257);
    send_angle(46080);
    send_angle(46080);
    send_angle(46080);
    send_angle(65535);
    send_angle(46080);
    send_angle(-65536);
    send_angle(-46080);
    send_angle(1);
    send_angle(-1);
    send_angle(0);
    drain_pipeline();

    // Floor above the ceiling, plus a write to the unused slot.
    write_reg(REG_DUTY_FLOOR, 20000);
    write_reg(REG_DUTY_CEILING, 10000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_angle(0);
    send_angle(300);
    send_angle(4096);
    send_angle(-46080);
    drain_pipeline();

    // Random phases; the fourth and the last run without any idling.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       load_drive_config(1048575, 1048575, 1048575, 262143, 0, 25600, 0);
        1:       load_drive_config(0, 0, 0, 0, 0, 0, 65535);
        2:       load_drive_config(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                                   32767, 0, $urandom_range(0, 46080));
        default: load_drive_config(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                                   rand_duty(), rand_duty(),
                                   ($urandom_range(0, 7) == 0) ? 65535
                                                               : $urandom_range(0, 46080));
      endcase
      idling     = (ph != 3) && (ph != PHASE_COUNT - 1);
      walk_angle = 0;
      repeat (PHASE_ITEMS) send_angle(pick_angle());
      drain_pipeline();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bpmd_pkg.sv
design/bpmd_regs.sv
design/bpmd_integ.sv
design/bpmd_gain.sv
design/bpmd_shape.sv
design/balance_pid_motor_drive.sv
dv/bpmd_drive_checker.sv
dv/tb_top.sv
